/* hw/rtl/lmfs_pkg.sv */
// shared types, opcodes and digit font for the led matrix frame store
// depends on nothing; imported by every module of the block
package lmfs_pkg;

  // default and largest store depth in columns
  localparam int unsigned DefColumns = 32;
  localparam int unsigned MaxColumns = 64;

  // command address width: covers the largest store plus glyph overhang
  localparam int unsigned ADDR_W = 7;

  // command opcodes
  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_PIXEL = 2'd1,
    OP_DIGIT = 2'd2,
    OP_SEND  = 2'd3
  } lmfs_op_e;

  // largest digit the font holds
  localparam logic [3:0] MaxDigit = 4'd9;

  // input request
  typedef struct packed {
    logic [1:0] opcode;
    logic [4:0] column;
    logic [2:0] row;
    logic       pixel_on;
    logic [3:0] digit;
  } lmfs_in_t;

  // output request
  typedef struct packed {
    logic [7:0] data_byte;
    logic [4:0] out_index;
    logic       last;
  } lmfs_out_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic              latch;      // capture row, pixel_on and digit
    logic              clear_all;  // drop every column to zero
    logic              rd_en;      // read one column
    logic              rd_tile;    // read goes into the tile buffer
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_pix;     // write back read column with one bit changed
    logic              wr_glyph;   // write one glyph column
    logic [1:0]        glyph_idx;
    logic [ADDR_W-1:0] wr_addr;
    logic              emit;       // load the output register
    logic [2:0]        bit_sel;    // tile bit row to send
    logic [4:0]        index;
    logic              last;
  } lmfs_cmd_t;

  // 3x5 digit font, one column at a time, bit 0 is the top row
  function automatic logic [4:0] lmfs_glyph(input logic [3:0] d, input logic [1:0] c);
    logic [14:0] cols;  // {col2, col1, col0}
    logic [4:0]  res;
    case (d)
      4'd0:    cols = {5'b11111, 5'b10001, 5'b11111};
      4'd1:    cols = {5'b10000, 5'b11111, 5'b10010};
      4'd2:    cols = {5'b10111, 5'b10101, 5'b11101};
      4'd3:    cols = {5'b11111, 5'b10101, 5'b10001};
      4'd4:    cols = {5'b11110, 5'b00100, 5'b00111};
      4'd5:    cols = {5'b11101, 5'b10101, 5'b10111};
      4'd6:    cols = {5'b11101, 5'b10101, 5'b11111};
      4'd7:    cols = {5'b11111, 5'b00001, 5'b00001};
      4'd8:    cols = {5'b11111, 5'b10101, 5'b11111};
      4'd9:    cols = {5'b11111, 5'b10101, 5'b10111};
      default: cols = '0;
    endcase
    case (c)
      2'd0:    res = cols[4:0];
      2'd1:    res = cols[9:5];
      2'd2:    res = cols[14:10];
      default: res = '0;
    endcase
    return res;
  endfunction

endpackage

/* hw/rtl/lmfs_datapath.sv */
// frame store memory with per-column valid bits, tile buffer and output register
// depends on lmfs_pkg; driven by lmfs_ctrl through lmfs_cmd_t
module lmfs_datapath import lmfs_pkg::*; #(
  parameter int unsigned COLUMNS = DefColumns
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  lmfs_in_t  in_data_i,
  input  lmfs_cmd_t cmd_i,
  input  logic      out_ready_i,
  output logic      out_free_o,
  output logic      out_valid_o,
  output lmfs_out_t out_data_o
);

  localparam int unsigned AW = $clog2(COLUMNS);

  logic [7:0]       mem_q [COLUMNS];
  logic [COLUMNS-1:0] valid_q;
  logic [7:0]       rd_data_q;
  logic             rd_ok_q;
  logic             tile_pend_q;
  logic [2:0]       tile_idx_q;
  logic [7:0]       tile_q [8];
  logic [2:0]       row_q;
  logic             pixel_on_q;
  logic [3:0]       digit_q;
  logic             out_valid_q;
  lmfs_out_t        out_q;

  logic [7:0]       rd_val;
  logic [7:0]       pix_mask;
  logic [7:0]       pix_data;
  logic [7:0]       glyph_data;
  logic [7:0]       xpose;
  logic [AW-1:0]    rd_idx;
  logic [AW-1:0]    wr_idx;

  assign rd_idx = cmd_i.rd_addr[AW-1:0];
  assign wr_idx = cmd_i.wr_addr[AW-1:0];

  // column read value, unwritten or out-of-range columns are zero
  assign rd_val     = rd_ok_q ? rd_data_q : 8'h00;
  assign pix_mask   = 8'h01 << row_q;
  assign pix_data   = pixel_on_q ? (rd_val | pix_mask) : (rd_val & ~pix_mask);
  assign glyph_data = 8'(lmfs_glyph(digit_q, cmd_i.glyph_idx)) << row_q;

  // transpose: bit j is the selected row bit of tile column j
  always_comb begin
    for (int j = 0; j < 8; j++) begin
      xpose[j] = tile_q[j][cmd_i.bit_sel];
    end
  end

  // request field capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      row_q      <= in_data_i.row;
      pixel_on_q <= in_data_i.pixel_on;
      digit_q    <= in_data_i.digit;
    end
  end

  // memory write port
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_pix) begin
      mem_q[wr_idx] <= pix_data;
    end else if (cmd_i.wr_glyph) begin
      mem_q[wr_idx] <= glyph_data;
    end
  end

  // memory read port, registered
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rd_data_q <= mem_q[rd_idx];
    end
  end

  // valid bits and read qualifiers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      rd_ok_q     <= 1'b0;
      tile_pend_q <= 1'b0;
      tile_idx_q  <= '0;
    end else begin
      if (cmd_i.clear_all) begin
        valid_q <= '0;
      end else if (cmd_i.wr_pix || cmd_i.wr_glyph) begin
        valid_q[wr_idx] <= 1'b1;
      end
      if (cmd_i.rd_en) begin
        rd_ok_q <= (cmd_i.rd_addr < ADDR_W'(COLUMNS)) && valid_q[rd_idx];
      end
      tile_pend_q <= cmd_i.rd_en && cmd_i.rd_tile;
      tile_idx_q  <= cmd_i.rd_addr[2:0];
    end
  end

  // tile buffer fill
  always_ff @(posedge clk_i) begin
    if (tile_pend_q) begin
      tile_q[tile_idx_q] <= rd_val;
    end
  end

  // output register
  assign out_free_o = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q.data_byte <= xpose;
      out_q.out_index <= cmd_i.index;
      out_q.last      <= cmd_i.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // a pixel write always follows its own column read
  a_pix_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wr_pix |-> $past(cmd_i.rd_en) && !$past(cmd_i.rd_tile))
    else $error("pixel write without preceding read");

  // tile capture only lands after a tile read
  a_tile_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tile_pend_q |-> $past(cmd_i.rd_tile))
    else $error("tile capture without tile read");

  // emit never overwrites a byte the receiver has not taken
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> out_free_o)
    else $error("output register overwritten");

endmodule

/* hw/rtl/lmfs_ctrl.sv */
// command sequencer for the led matrix frame store
// depends on lmfs_pkg; drives lmfs_datapath through lmfs_cmd_t
module lmfs_ctrl import lmfs_pkg::*; #(
  parameter int unsigned COLUMNS = DefColumns
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  lmfs_in_t  in_data_i,
  input  logic      out_free_i,
  output lmfs_cmd_t cmd_o
);

  localparam int unsigned IW = $clog2(COLUMNS);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_PIX   = 6'b000010,
    ST_GLYPH = 6'b000100,
    ST_LOAD  = 6'b001000,
    ST_LWAIT = 6'b010000,
    ST_EMIT  = 6'b100000
  } lmfs_state_e;

  lmfs_state_e       state_q, state_d;
  logic [ADDR_W-1:0] col_q, col_d;
  logic [2:0]        k_q, k_d;
  logic [IW-1:0]     i_q, i_d;

  logic              accept;
  logic [ADDR_W-1:0] in_col;
  logic [ADDR_W-1:0] glyph_addr;
  logic              last_byte;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign in_col     = ADDR_W'(in_data_i.column);
  assign glyph_addr = col_q + ADDR_W'(k_q);
  assign last_byte  = (i_q == IW'(COLUMNS - 1));

  // next state and command decode
  always_comb begin
    state_d = state_q;
    col_d   = col_q;
    k_d     = k_q;
    i_d     = i_q;
    cmd_o   = '0;
    cmd_o.bit_sel = i_q[2:0];
    cmd_o.index   = 5'(i_q);
    cmd_o.last    = last_byte;
    // tile base column plus column within the tile
    cmd_o.rd_addr = (ADDR_W'(i_q) & ~ADDR_W'(7)) | ADDR_W'(k_q);
    cmd_o.wr_addr = col_q;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.latch = accept;
        if (accept) begin
          unique case (lmfs_op_e'(in_data_i.opcode))
            OP_CLEAR: cmd_o.clear_all = 1'b1;
            OP_PIXEL: begin
              if (in_col < ADDR_W'(COLUMNS)) begin
                cmd_o.rd_en   = 1'b1;
                cmd_o.rd_addr = in_col;
                col_d         = in_col;
                state_d       = ST_PIX;
              end
            end
            OP_DIGIT: begin
              if (in_data_i.digit <= MaxDigit) begin
                col_d   = in_col;
                k_d     = '0;
                state_d = ST_GLYPH;
              end
            end
            OP_SEND: begin
              k_d     = '0;
              i_d     = '0;
              state_d = ST_LOAD;
            end
            default: ;
          endcase
        end
      end
      // read-modify-write of one column
      ST_PIX: begin
        cmd_o.wr_pix = 1'b1;
        state_d      = ST_IDLE;
      end
      // three glyph columns, dropped past the edge
      ST_GLYPH: begin
        cmd_o.wr_glyph  = (glyph_addr < ADDR_W'(COLUMNS));
        cmd_o.wr_addr   = glyph_addr;
        cmd_o.glyph_idx = k_q[1:0];
        k_d             = k_q + 3'd1;
        if (k_q == 3'd2) begin
          state_d = ST_IDLE;
        end
      end
      // read the eight columns of the current tile
      ST_LOAD: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_tile = 1'b1;
        k_d           = k_q + 3'd1;
        if (k_q == 3'd7) begin
          state_d = ST_LWAIT;
        end
      end
      // last tile column lands
      ST_LWAIT: state_d = ST_EMIT;
      // send the tile one row byte at a time
      ST_EMIT: begin
        if (out_free_i) begin
          cmd_o.emit = 1'b1;
          i_d        = i_q + IW'(1);
          if (last_byte) begin
            i_d     = '0;
            state_d = ST_IDLE;
          end else if (i_q[2:0] == 3'd7) begin
            k_d     = '0;
            state_d = ST_LOAD;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // state and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      col_q   <= '0;
      k_q     <= '0;
      i_q     <= '0;
    end else begin
      state_q <= state_d;
      col_q   <= col_d;
      k_q     <= k_d;
      i_q     <= i_d;
    end
  end

  // glyph writes never leave the store
  a_glyph_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.wr_glyph |-> cmd_o.wr_addr < ADDR_W'(COLUMNS))
    else $error("glyph write out of range");

  // final byte of a send returns to idle
  a_last_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit && cmd_o.last |=> state_q == ST_IDLE)
    else $error("send did not end after last byte");

  // last flag only on the final index
  a_last_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit && cmd_o.last |-> cmd_o.index == 5'(COLUMNS - 1))
    else $error("last flag on wrong index");

endmodule

/* hw/rtl/led_matrix_frame_store_transpose.sv */
// LED matrix frame store with 8x8 tile transpose on send
// Requests enter on in_valid_i/in_ready_o as lmfs_in_t; sent bytes leave on
// out_valid_o/out_ready_i as lmfs_out_t.
// Opcodes: clear zeroes every column, set pixel changes one bit, print digit
// writes a 3x5 font glyph over three columns shifted down by row, send emits
// COLUMNS bytes, each group of eight columns transposed as an 8x8 tile.
// Steps per request, counted from acceptance to the next ready:
//   clear is done on acceptance; set pixel reads the column, then writes it
//   back; print digit writes one glyph column per cycle through the single
//   write port; send, per tile: eight reads fill the tile buffer, a wait
//   state lets the last read land, then the eight bytes are emitted.
// Within a tile the bytes leave one per cycle while out_ready_i stays high.
// A stall on out_ready_i holds the output register and freezes the send; the
// last byte may still wait while the next request is accepted.
// Reset clears the per-column valid bits at once, so the store reads as zero
// right away; there is no clearing pass.
module led_matrix_frame_store_transpose import lmfs_pkg::*; #(
  parameter int unsigned COLUMNS = DefColumns
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  lmfs_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output lmfs_out_t out_data_o
);

  lmfs_cmd_t cmd;
  logic      out_free;

  // sequencer
  lmfs_ctrl #(
    .COLUMNS (COLUMNS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_free_i (out_free),
    .cmd_o      (cmd)
  );

  // store, tile buffer and output register
  lmfs_datapath #(
    .COLUMNS (COLUMNS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .out_ready_i (out_ready_i),
    .out_free_o  (out_free),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule
